// File: hw/rtl/dhmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhmu_pkg: shared types and constants for the diagonal Hessian momentum update
// Holds the request and response payload structs and the register indexes.
// ----------------------------------------------------------------------------
package dhmu_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] REG_MOM_GRAD_EARLY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOM_CURV_EARLY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOM_GRAD_LATE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOM_CURV_LATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_WEIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_BIAS      = 3'd6;

   localparam logic [16:0] MOM_ONE = 17'd65536;
   localparam int unsigned MOM_BITS = 16;

   typedef struct packed {
      logic [15:0]        iteration;
      logic               is_bias;
      logic signed [31:0] param_in;
      logic signed [31:0] velocity_in;
      logic signed [31:0] curvature_in;
      logic signed [31:0] gradient;
      logic signed [31:0] second_deriv;
   } req_type;

   typedef struct packed {
      logic signed [31:0] param_out;
      logic signed [31:0] velocity_out;
      logic signed [31:0] curvature_out;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/dhmu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhmu_div: pipelined restoring divider
// One quotient bit per stage, a new division may enter every cycle. Quotient
// is clamped to INT32_MAX; a non-positive divisor also yields INT32_MAX.
// ----------------------------------------------------------------------------
module dhmu_div #(
   parameter int unsigned NUM_W = 47,  // dividend width
   parameter int unsigned DEN_W = 33,  // divisor width (positive when flagged)
   parameter int unsigned TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic             in_den_ok,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [31:0]           out_quot,
   output logic [TAG_W-1:0]      out_tag
);

   localparam int unsigned REM_W = DEN_W + 1;

   logic [NUM_W:0]            valid_ff;
   logic [NUM_W-1:0]          num_ff [NUM_W+1];
   logic [REM_W-1:0]          rem_ff [NUM_W+1];
   logic [DEN_W-1:0]          den_ff [NUM_W+1];
   logic [NUM_W:0]            ok_ff;
   logic [TAG_W-1:0]          tag_ff [NUM_W+1];

   // stage 0 captures the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      num_ff[0] <= in_num;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
      ok_ff[0]  <= in_den_ok;
      tag_ff[0] <= in_tag;
   end

   // one quotient bit per stage, quotient shifts into num from the bottom
   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [REM_W-1:0] trial_in;
      logic [REM_W:0]   diff_in;
      always_comb begin
         trial_in = {rem_ff[k][REM_W-2:0], num_ff[k][NUM_W-1]};
         diff_in  = {1'b0, trial_in} - {2'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (!diff_in[REM_W]) begin
            rem_ff[k+1] <= diff_in[REM_W-1:0];
            num_ff[k+1] <= {num_ff[k][NUM_W-2:0], 1'b1};
         end else begin
            rem_ff[k+1] <= trial_in;
            num_ff[k+1] <= {num_ff[k][NUM_W-2:0], 1'b0};
         end
         den_ff[k+1] <= den_ff[k];
         ok_ff[k+1]  <= ok_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   // clamp and flag
   always_comb begin
      out_valid = valid_ff[NUM_W];
      out_tag   = tag_ff[NUM_W];
      if (!ok_ff[NUM_W] || (|num_ff[NUM_W][NUM_W-1:31])) begin
         out_quot = 32'h7FFF_FFFF;
      end else begin
         out_quot = {1'b0, num_ff[NUM_W][30:0]};
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/diag_hessian_momentum_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diag_hessian_momentum_update: diagonal Hessian momentum parameter update
// Updates curvature, computes step = rate/(s'+damping), updates velocity and
// returns the new parameter, velocity and curvature.
//
//  channel | ports                              | transfer when
//  request | start, busy, req_data              | start && !busy
//  result  | rsp_valid, rsp_data                | rsp_valid (one cycle)
//  config  | csr_we, csr_index, csr_wdata       | csr_we
//
// One element enters every cycle; busy is tied low.
// Most of the pipeline is the divider, which resolves one quotient bit
// per stage over its 31+FRAC_BITS stages.
// Reset is synchronous, clears the valid bits and loads the configuration registers with their defaults.
// The receiver cannot stall; results appear in input order.
// ----------------------------------------------------------------------------
module diag_hessian_momentum_update #(
   parameter int unsigned SWITCH_ITERATION = 30,
   parameter int unsigned FRAC_BITS        = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire dhmu_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   output dhmu_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [dhmu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dhmu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned NUM_W = 31 + FRAC_BITS;
   localparam int unsigned TAG_W = 32 + 32 + 32 + 32 + 17;

   // ---------------------------------------------------------------------
   // configuration registers
   logic [16:0] mge_ff, mce_ff, mgl_ff, mcl_ff;
   logic [30:0] damp_ff, rw_ff, rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mge_ff  <= 17'd32768;
         mce_ff  <= 17'd32768;
         mgl_ff  <= 17'd58982;
         mcl_ff  <= 17'd58982;
         damp_ff <= 31'd655;
         rw_ff   <= 31'd655;
         rb_ff   <= 31'd655;
      end else if (csr_we) begin
         unique case (csr_index)
            dhmu_pkg::REG_MOM_GRAD_EARLY: mge_ff  <= csr_wdata[16:0];
            dhmu_pkg::REG_MOM_CURV_EARLY: mce_ff  <= csr_wdata[16:0];
            dhmu_pkg::REG_MOM_GRAD_LATE:  mgl_ff  <= csr_wdata[16:0];
            dhmu_pkg::REG_MOM_CURV_LATE:  mcl_ff  <= csr_wdata[16:0];
            dhmu_pkg::REG_DAMPING:        damp_ff <= csr_wdata;
            dhmu_pkg::REG_RATE_WEIGHT:    rw_ff   <= csr_wdata;
            dhmu_pkg::REG_RATE_BIAS:      rb_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   function automatic logic [16:0] clamp_mom(input logic [16:0] r);
      return (r > dhmu_pkg::MOM_ONE) ? dhmu_pkg::MOM_ONE : r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -66'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // ---------------------------------------------------------------------
   // stage 1: select momenta and rate, capture operands
   logic        s1_valid_ff;
   logic [16:0] s1_m_ff, s1_m2_ff;
   logic [30:0] s1_rate_ff;
   logic signed [31:0] s1_w_ff, s1_v_ff, s1_s_ff, s1_g_ff, s1_d2_ff;
   logic        late_in;

   assign late_in = {16'd0, req_data.iteration} >= 32'(SWITCH_ITERATION);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start;
      s1_m_ff    <= clamp_mom(late_in ? mgl_ff : mge_ff);
      s1_m2_ff   <= clamp_mom(late_in ? mcl_ff : mce_ff);
      s1_rate_ff <= req_data.is_bias ? rb_ff : rw_ff;
      s1_w_ff    <= req_data.param_in;
      s1_v_ff    <= req_data.velocity_in;
      s1_s_ff    <= req_data.curvature_in;
      s1_g_ff    <= req_data.gradient;
      s1_d2_ff   <= req_data.second_deriv;
   end

   // stage 2: curvature products
   logic        s2_valid_ff;
   logic signed [49:0] s2_p1_ff, s2_p2_ff;
   logic [16:0] s2_m_ff;
   logic [30:0] s2_rate_ff;
   logic signed [31:0] s2_w_ff, s2_v_ff, s2_g_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_p1_ff   <= 50'(s1_s_ff) * 50'($signed({1'b0, s1_m2_ff}));
      s2_p2_ff   <= 50'(s1_d2_ff) *
                    50'($signed({1'b0, dhmu_pkg::MOM_ONE - s1_m2_ff}));
      s2_m_ff    <= s1_m_ff;
      s2_rate_ff <= s1_rate_ff;
      s2_w_ff    <= s1_w_ff;
      s2_v_ff    <= s1_v_ff;
      s2_g_ff    <= s1_g_ff;
   end

   // stage 3: round and saturate the new curvature
   logic        s3_valid_ff;
   logic signed [31:0] s3_snew_ff;
   logic [16:0] s3_m_ff;
   logic [30:0] s3_rate_ff;
   logic signed [31:0] s3_w_ff, s3_v_ff, s3_g_ff;
   logic signed [50:0] csum_in;

   assign csum_in = 51'(s2_p1_ff) + 51'(s2_p2_ff) + 51'sd32768;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_snew_ff <= sat32(66'(csum_in >>> 16));
      s3_m_ff    <= s2_m_ff;
      s3_rate_ff <= s2_rate_ff;
      s3_w_ff    <= s2_w_ff;
      s3_v_ff    <= s2_v_ff;
      s3_g_ff    <= s2_g_ff;
   end

   // stage 4: divisor = s' + damping, feed the divider
   logic signed [32:0] den_in;
   logic [NUM_W-1:0]   num_in;
   logic [TAG_W-1:0]   tag_in;
   logic               dv_valid;
   logic [31:0]        dv_quot;
   logic [TAG_W-1:0]   dv_tag;

   always_comb begin
      den_in = 33'(s3_snew_ff) + $signed({2'b0, damp_ff});
      num_in = {s3_rate_ff, FRAC_BITS'(0)};
      tag_in = {s3_w_ff, s3_v_ff, s3_g_ff, s3_snew_ff, s3_m_ff};
   end

   dhmu_div #(.NUM_W(NUM_W), .DEN_W(33), .TAG_W(TAG_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (num_in),
      .in_den    (den_in),
      .in_den_ok (den_in > 33'sd0),
      .in_tag    (tag_in),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tag   (dv_tag)
   );

   logic signed [31:0] dw, dv, dg, ds;
   logic [16:0]        dm;
   assign {dw, dv, dg, ds, dm} = dv_tag;

   // stage 5: gradient times step (step never exceeds INT32_MAX)
   logic        s5_valid_ff;
   logic signed [63:0] s5_gs_ff;
   logic signed [31:0] s5_w_ff, s5_v_ff, s5_s_ff;
   logic [16:0] s5_m_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else       s5_valid_ff <= dv_valid;
      s5_gs_ff <= 64'(dg) * 64'($signed(dv_quot));
      s5_w_ff  <= dw;
      s5_v_ff  <= dv;
      s5_s_ff  <= ds;
      s5_m_ff  <= dm;
   end

   // stage 6: round and saturate g*step
   logic        s6_valid_ff;
   logic signed [31:0] s6_gs_ff, s6_w_ff, s6_v_ff, s6_s_ff;
   logic [16:0] s6_m_ff;
   logic signed [64:0] gsr_in;

   assign gsr_in = 65'(s5_gs_ff) + (65'sd1 <<< (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else       s6_valid_ff <= s5_valid_ff;
      s6_gs_ff <= sat32(66'(gsr_in >>> FRAC_BITS));
      s6_w_ff  <= s5_w_ff;
      s6_v_ff  <= s5_v_ff;
      s6_s_ff  <= s5_s_ff;
      s6_m_ff  <= s5_m_ff;
   end

   // stage 7: velocity products
   logic        s7_valid_ff;
   logic signed [49:0] s7_p1_ff, s7_p2_ff;
   logic signed [31:0] s7_w_ff, s7_s_ff;

   always_ff @(posedge clock) begin
      if (reset) s7_valid_ff <= 1'b0;
      else       s7_valid_ff <= s6_valid_ff;
      s7_p1_ff <= 50'(s6_v_ff) * 50'($signed({1'b0, s6_m_ff}));
      s7_p2_ff <= 50'(s6_gs_ff) *
                  50'($signed({1'b0, dhmu_pkg::MOM_ONE - s6_m_ff}));
      s7_w_ff  <= s6_w_ff;
      s7_s_ff  <= s6_s_ff;
   end

   // stage 8: new velocity
   logic        s8_valid_ff;
   logic signed [31:0] s8_v_ff, s8_w_ff, s8_s_ff;
   logic signed [50:0] vsum_in;

   assign vsum_in = 51'(s7_p1_ff) + 51'(s7_p2_ff) + 51'sd32768;

   always_ff @(posedge clock) begin
      if (reset) s8_valid_ff <= 1'b0;
      else       s8_valid_ff <= s7_valid_ff;
      s8_v_ff <= sat32(66'(vsum_in >>> 16));
      s8_w_ff <= s7_w_ff;
      s8_s_ff <= s7_s_ff;
   end

   // stage 9: new parameter, output register
   logic              rsp_valid_ff;
   dhmu_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s8_valid_ff;
      rsp_data_ff.param_out     <= sat32(66'(s8_w_ff) - 66'(s8_v_ff));
      rsp_data_ff.velocity_out  <= s8_v_ff;
      rsp_data_ff.curvature_out <= s8_s_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // momenta are clamped to one before use
   a_mom_clamp: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_m_ff <= dhmu_pkg::MOM_ONE) else $error("momentum above one");
   // a valid result follows a valid divider output
   a_flow: assert property (@(posedge clock) disable iff (reset)
      dv_valid |-> ##5 rsp_valid) else $error("lost result");
   a_flow2: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |=> u_div.valid_ff[0]) else $error("lost item at divider");

endmodule
`default_nettype wire

// File: tb/sv/dhmu_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhmu_update_checker: result checker for the diagonal Hessian momentum update
// Mirrors the register file from observed writes, computes the expected
// parameter, velocity and curvature for every accepted element, and compares
// each result transfer against the oldest expected value in order.
// ----------------------------------------------------------------------------
module dhmu_update_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               busy,
   input  wire dhmu_pkg::req_type                  req_data,
   input  wire logic                               rsp_valid,
   input  wire dhmu_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [dhmu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dhmu_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                      error_count,
   output int                                      pending_count
);

   localparam int unsigned SWITCH_AT = 30;
   localparam int unsigned FRAC      = 16;
   localparam longint      I32_MAX   = 64'sd2147483647;
   localparam longint      I32_MIN   = -64'sd2147483648;

   logic [16:0] mg_early, mc_early, mg_late, mc_late;
   logic [30:0] damp_reg, rate_w_reg, rate_b_reg;
   dhmu_pkg::rsp_type update_queue[$];

   function automatic longint clamp32(longint x);
      if (x > I32_MAX) return I32_MAX;
      if (x < I32_MIN) return I32_MIN;
      return x;
   endfunction

   // round half up, then drop k bits (arithmetic shift floors)
   function automatic longint round_drop(longint x, int k);
      return (x + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clip_mom(logic [16:0] r);
      return (r > dhmu_pkg::MOM_ONE) ? longint'(dhmu_pkg::MOM_ONE) : longint'(r);
   endfunction

   function automatic dhmu_pkg::rsp_type predict_update(dhmu_pkg::req_type r);
      dhmu_pkg::rsp_type res;
      longint  m, m2, rate, w, v, s, g, d2, s_new, div, step, gs, v_new;
      bit      late;
      late  = r.iteration >= SWITCH_AT;
      m     = clip_mom(late ? mg_late : mg_early);
      m2    = clip_mom(late ? mc_late : mc_early);
      rate  = r.is_bias ? longint'(rate_b_reg) : longint'(rate_w_reg);
      w     = longint'(r.param_in);
      v     = longint'(r.velocity_in);
      s     = longint'(r.curvature_in);
      g     = longint'(r.gradient);
      d2    = longint'(r.second_deriv);
      s_new = clamp32(round_drop(s * m2 + d2 * (65536 - m2), dhmu_pkg::MOM_BITS));
      div   = s_new + longint'(damp_reg);
      if (div <= 0) begin
         step = I32_MAX;
      end else begin
         step = (rate <<< FRAC) / div;
         if (step > I32_MAX) step = I32_MAX;
      end
      gs    = clamp32(round_drop(g * step, FRAC));
      v_new = clamp32(round_drop(v * m + gs * (65536 - m), dhmu_pkg::MOM_BITS));
      res.param_out     = 32'(clamp32(w - v_new));
      res.velocity_out  = 32'(v_new);
      res.curvature_out = 32'(s_new);
      return res;
   endfunction

   assign pending_count = update_queue.size();

   initial error_count = 0;

   // register mirror, prediction on request transfer, compare on result
   always @(posedge clock) begin
      dhmu_pkg::rsp_type exp_r;
      if (reset) begin
         mg_early   <= 17'd32768;
         mc_early   <= 17'd32768;
         mg_late    <= 17'd58982;
         mc_late    <= 17'd58982;
         damp_reg   <= 31'd655;
         rate_w_reg <= 31'd655;
         rate_b_reg <= 31'd655;
         update_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               dhmu_pkg::REG_MOM_GRAD_EARLY: mg_early   <= csr_wdata[16:0];
               dhmu_pkg::REG_MOM_CURV_EARLY: mc_early   <= csr_wdata[16:0];
               dhmu_pkg::REG_MOM_GRAD_LATE:  mg_late    <= csr_wdata[16:0];
               dhmu_pkg::REG_MOM_CURV_LATE:  mc_late    <= csr_wdata[16:0];
               dhmu_pkg::REG_DAMPING:        damp_reg   <= csr_wdata;
               dhmu_pkg::REG_RATE_WEIGHT:    rate_w_reg <= csr_wdata;
               dhmu_pkg::REG_RATE_BIAS:      rate_b_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) update_queue.push_back(predict_update(req_data));
         if (rsp_valid) begin
            if (update_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               exp_r = update_queue.pop_front();
               if (rsp_data.param_out !== exp_r.param_out) begin
                  $display("%0t: param_out expected %h actual %h", $time,
                           exp_r.param_out, rsp_data.param_out);
                  error_count++;
               end
               if (rsp_data.velocity_out !== exp_r.velocity_out) begin
                  $display("%0t: velocity_out expected %h actual %h", $time,
                           exp_r.velocity_out, rsp_data.velocity_out);
                  error_count++;
               end
               if (rsp_data.curvature_out !== exp_r.curvature_out) begin
                  $display("%0t: curvature_out expected %h actual %h", $time,
                           exp_r.curvature_out, rsp_data.curvature_out);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

// File: tb/sv/diag_hessian_momentum_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diag_hessian_momentum_update_tb: stimulus for the momentum update block
// Directed corner elements, then random elements over several register
// settings and sender idle patterns; the checker reports mismatches.
// ----------------------------------------------------------------------------
module diag_hessian_momentum_update_tb;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   dhmu_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   dhmu_pkg::rsp_type               rsp_data;
   logic                            csr_we = 1'b0;
   logic [dhmu_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dhmu_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                              error_count, pending_count;
   int                              idle_pct;

   diag_hessian_momentum_update dut (.*);
   dhmu_update_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // element values: corners, small Q16.16 values, or any 32 bits
   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
         1, 2, 3: return $urandom_range(0, 1 << 21) - (1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic dhmu_pkg::req_type random_element();
      dhmu_pkg::req_type r;
      r.iteration    = $urandom_range(1) ? 16'($urandom_range(0, 60)) : 16'($urandom);
      r.is_bias      = 1'($urandom_range(1));
      r.param_in     = pick_value();
      r.velocity_in  = pick_value();
      r.curvature_in = pick_value();
      r.gradient     = pick_value();
      r.second_deriv = pick_value();
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_element(dhmu_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(logic [dhmu_pkg::CSR_IDX_W-1:0] idx,
                            logic [dhmu_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_regs(logic [16:0] mge, logic [16:0] mce, logic [16:0] mgl,
                           logic [16:0] mcl, logic [30:0] dmp, logic [30:0] rw,
                           logic [30:0] rb);
      write_reg(dhmu_pkg::REG_MOM_GRAD_EARLY, 31'(mge));
      write_reg(dhmu_pkg::REG_MOM_CURV_EARLY, 31'(mce));
      write_reg(dhmu_pkg::REG_MOM_GRAD_LATE, 31'(mgl));
      write_reg(dhmu_pkg::REG_MOM_CURV_LATE, 31'(mcl));
      write_reg(dhmu_pkg::REG_DAMPING, dmp);
      write_reg(dhmu_pkg::REG_RATE_WEIGHT, rw);
      write_reg(dhmu_pkg::REG_RATE_BIAS, rb);
   endtask

   task automatic random_phase(int n, int pct);
      idle_pct = pct;
      repeat (n) send_element(random_element());
      drain();
   endtask

   initial begin
      dhmu_pkg::req_type r;
      idle_pct = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset registers, iteration switch, both rates, extremes
      r = '0;
      r.curvature_in = 32'sh0001_0000;
      r.gradient     = 32'sh0001_0000;
      r.iteration = 16'd0;     send_element(r);
      r.iteration = 16'd29;    send_element(r);
      r.iteration = 16'd30;    send_element(r);
      r.iteration = 16'd31;    send_element(r);
      r.iteration = 16'hFFFF;  r.is_bias = 1'b1; send_element(r);
      // non-positive divisor from a very negative curvature
      r.curvature_in = 32'sh8000_0000;
      r.second_deriv = 32'sh8000_0000;
      send_element(r);
      // saturating gradient-step product and all extremes
      r = '{16'hFFFF, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000};
      send_element(r);
      r = '{16'h0, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF};
      send_element(r);
      drain();

      // momentum above one, zero damping, largest rates
      set_regs(17'h1FFFF, 17'h1FFFF, 17'd65537, 17'd65536, 31'd0,
               31'h7FFF_FFFF, 31'h7FFF_FFFF);
      r = '{16'd5, 1'b0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0001_0000,
            32'sh0003_0000};
      send_element(r);
      r.iteration = 16'd40; r.is_bias = 1'b1; r.gradient = 32'shFFFF_0000;
      send_element(r);
      r.curvature_in = 32'sh7FFF_FFFF; send_element(r);
      drain();

      // zero momenta, smallest damping, zero rates
      set_regs(17'd0, 17'd0, 17'd0, 17'd0, 31'd1, 31'd0, 31'd0);
      random_phase(150, 0);

      // reset-like values, sender back to back
      set_regs(17'd32768, 17'd32768, 17'd58982, 17'd58982, 31'd655, 31'd655, 31'd655);
      random_phase(350, 0);

      // random settings under different idle patterns
      set_regs(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 131071)),
               17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
               31'($urandom_range(1, 1 << 20)), 31'($urandom_range(0, 1 << 22)),
               31'($urandom));
      random_phase(350, 88);

      set_regs(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
               17'($urandom_range(0, 131071)), 17'($urandom_range(0, 65536)),
               31'($urandom), 31'($urandom),
               31'($urandom_range(0, 1 << 22)));
      random_phase(350, 23);

      set_regs(17'd65536, 17'd65536, 17'd65535, 17'd1, 31'h7FFF_FFFF,
               31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)));
      random_phase(300, 0);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run time guard
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/dhmu_pkg.sv
hw/rtl/dhmu_div.sv
hw/rtl/diag_hessian_momentum_update.sv
tb/sv/dhmu_update_checker.sv
tb/sv/diag_hessian_momentum_update_tb.sv
